### rtl/hdnc_pkg.sv
// Shared types and constants for the heredoc and nested comment scanner.
// No dependencies.
package hdnc_pkg;

    // Sizing
    localparam int MAX_DELIMITER = 256;
    localparam int MAX_NESTING   = 255;
    localparam int DLEN_W        = $clog2(MAX_DELIMITER);
    localparam int DEPTH_W       = $clog2(MAX_NESTING + 1);

    // Characters of interest
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // Result status codes
    localparam logic [2:0] ST_CONT   = 3'd0;
    localparam logic [2:0] ST_HD_END = 3'd1;
    localparam logic [2:0] ST_HD_EOF = 3'd2;
    localparam logic [2:0] ST_CM_END = 3'd3;
    localparam logic [2:0] ST_CM_EOF = 3'd4;
    localparam logic [2:0] ST_REJECT = 3'd5;

    typedef struct packed {
        logic [7:0] ch;
        logic       at_end;
        logic       heredoc_ok;
        logic       comment_ok;
    } in_beat_t;

    typedef struct packed {
        logic [2:0] status;
        logic       in_token;
    } out_beat_t;

    function automatic logic is_alpha_us(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c == 8'h5F;
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return is_alpha_us(c) || (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic is_follower(input logic [7:0] c);
        return c == CH_LF || c == CH_CR || c == CH_SP || c == CH_RPAR || c == CH_RBRK;
    endfunction

endpackage

### rtl/heredoc_and_nested_comment_scanner_top.sv
// Heredoc and nested block comment scanner, one character beat per cycle.
// Depends on hdnc_pkg.
//
// Usage:
//   s_ channel: one character beat (ch, at_end, heredoc_ok, comment_ok).
//   m_ channel: one result beat (status, in_token) for every input beat.
//   A beat moves when valid and ready are both high at a rising edge.
//   Latency: the result of a beat shows on m_ the cycle after it is taken.
//   Throughput: one beat per cycle unless m_ stalls. The delimiter store is a 1-port-write,
//   1-port-read memory whose read address is the next match position, so the
//   stored byte for the next body compare is already registered when the
//   next character arrives.
//   Stall: the result sits in the output register; s_ready drops only while
//   that register is full and m_ready is low, so nothing is lost or repeated.
//   Reset (aresetn low, synchronous): scanner goes idle, counters clear,
//   output register empties. The delimiter store is not cleared; only bytes
//   written for the current heredoc are ever compared.
module heredoc_and_nested_comment_scanner_top (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  hdnc_pkg::in_beat_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output hdnc_pkg::out_beat_t  m_data
);

    typedef enum logic [3:0] {
        M_IDLE, M_HASH, M_LT1, M_DFIRST, M_DNAME,
        M_BODY, M_SKIP, M_COMMENT, M_C_HASH, M_C_BAR
    } mode_t;

    mode_t                          mode_reg, mode_next;
    logic [hdnc_pkg::DLEN_W-1:0]    dlen_reg, dlen_next;
    logic [hdnc_pkg::DLEN_W-1:0]    mpos_reg, mpos_next;
    logic [hdnc_pkg::DEPTH_W-1:0]   depth_reg, depth_next;
    logic                           m_valid_reg;
    hdnc_pkg::out_beat_t            m_data_reg, res;

    logic [7:0] dstore [hdnc_pkg::MAX_DELIMITER];
    logic [7:0] rd_data_reg;
    logic [hdnc_pkg::DLEN_W-1:0] rd_addr;
    logic [hdnc_pkg::DLEN_W-1:0] wr_addr;
    logic       wr_en;

    logic       accept;
    logic [7:0] c;
    logic       eoi;
    logic [hdnc_pkg::DEPTH_W-1:0] depth_dec;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign c       = s_data.ch;
    assign eoi     = s_data.at_end;

    // Read address tracks where the next body compare will look
    assign rd_addr   = accept ? mpos_next : mpos_reg;
    assign depth_dec = (depth_reg != '0) ? depth_reg - 1'b1 : depth_reg;

    // Next-state and result for the beat at the input
    always_comb begin
        mode_next  = mode_reg;
        dlen_next  = dlen_reg;
        mpos_next  = mpos_reg;
        depth_next = depth_reg;
        wr_en      = 1'b0;
        wr_addr    = dlen_reg;
        res.status   = hdnc_pkg::ST_CONT;
        res.in_token = 1'b0;
        case (mode_reg)
            M_HASH: begin
                if (!eoi && c == hdnc_pkg::CH_LT && s_data.heredoc_ok) begin
                    mode_next = M_LT1;
                    res.in_token = 1'b1;
                end else if (!eoi && c == hdnc_pkg::CH_BAR && s_data.comment_ok) begin
                    mode_next  = M_COMMENT;
                    depth_next = hdnc_pkg::DEPTH_W'(1);
                    res.in_token = 1'b1;
                end else begin
                    res.status = hdnc_pkg::ST_REJECT;
                end
            end
            M_LT1: begin
                if (!eoi && c == hdnc_pkg::CH_LT) begin
                    mode_next = M_DFIRST;
                    res.in_token = 1'b1;
                end else begin
                    res.status = hdnc_pkg::ST_REJECT;
                end
            end
            M_DFIRST: begin
                // First delimiter char always lands at entry zero
                if (!eoi && hdnc_pkg::is_alpha_us(c)) begin
                    wr_en     = 1'b1;
                    wr_addr   = '0;
                    dlen_next = hdnc_pkg::DLEN_W'(1);
                    mode_next = M_DNAME;
                    res.in_token = 1'b1;
                end else begin
                    res.status = hdnc_pkg::ST_REJECT;
                end
            end
            M_DNAME: begin
                if (eoi) begin
                    res.status = hdnc_pkg::ST_REJECT;
                end else if (hdnc_pkg::is_ident(c)) begin
                    if (dlen_reg >= hdnc_pkg::DLEN_W'(hdnc_pkg::MAX_DELIMITER - 1)) begin
                        res.status = hdnc_pkg::ST_REJECT;
                    end else begin
                        wr_en     = 1'b1;
                        dlen_next = dlen_reg + 1'b1;
                        res.in_token = 1'b1;
                    end
                end else if (c == hdnc_pkg::CH_LF) begin
                    mode_next = M_BODY;
                    mpos_next = '0;
                    res.in_token = 1'b1;
                end else begin
                    res.status = hdnc_pkg::ST_REJECT;
                end
            end
            M_BODY: begin
                if (eoi) begin
                    res.status = hdnc_pkg::ST_HD_EOF;
                end else if (mpos_reg < dlen_reg) begin
                    res.in_token = 1'b1;
                    if (c == rd_data_reg) begin
                        mpos_next = mpos_reg + 1'b1;
                    end else if (c == hdnc_pkg::CH_LF) begin
                        mpos_next = '0;
                    end else begin
                        mode_next = M_SKIP;
                    end
                end else if (hdnc_pkg::is_follower(c)) begin
                    res.status = hdnc_pkg::ST_HD_END;
                end else begin
                    res.in_token = 1'b1;
                    mode_next = M_SKIP;
                end
            end
            M_SKIP: begin
                if (eoi) begin
                    res.status = hdnc_pkg::ST_HD_EOF;
                end else begin
                    res.in_token = 1'b1;
                    if (c == hdnc_pkg::CH_LF) begin
                        mode_next = M_BODY;
                        mpos_next = '0;
                    end
                end
            end
            M_COMMENT, M_C_HASH, M_C_BAR: begin
                if (eoi) begin
                    res.status = hdnc_pkg::ST_CM_EOF;
                end else begin
                    res.in_token = 1'b1;
                    if (mode_reg == M_C_HASH && c == hdnc_pkg::CH_BAR) begin
                        if (depth_reg < hdnc_pkg::DEPTH_W'(hdnc_pkg::MAX_NESTING)) begin
                            depth_next = depth_reg + 1'b1;
                        end
                        mode_next = M_COMMENT;
                    end else if (mode_reg == M_C_BAR && c == hdnc_pkg::CH_HASH) begin
                        depth_next = depth_dec;
                        if (depth_dec == '0) begin
                            res.status = hdnc_pkg::ST_CM_END;
                        end else begin
                            mode_next = M_COMMENT;
                        end
                    end else if (c == hdnc_pkg::CH_HASH) begin
                        mode_next = M_C_HASH;
                    end else if (c == hdnc_pkg::CH_BAR) begin
                        mode_next = M_C_BAR;
                    end else begin
                        mode_next = M_COMMENT;
                    end
                end
            end
            default: begin
                if (eoi) begin
                    res.status = hdnc_pkg::ST_REJECT;
                end else if (c == hdnc_pkg::CH_SP || c == hdnc_pkg::CH_TAB ||
                             c == hdnc_pkg::CH_CR || c == hdnc_pkg::CH_LF) begin
                    mode_next = M_IDLE;
                end else if (c == hdnc_pkg::CH_HASH) begin
                    mode_next = M_HASH;
                    res.in_token = 1'b1;
                end else begin
                    res.status = hdnc_pkg::ST_REJECT;
                end
            end
        endcase
        // Any decision drops back to idle
        if (res.status != hdnc_pkg::ST_CONT) begin
            mode_next = M_IDLE;
        end
    end

    // Delimiter store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (accept && wr_en) begin
            dstore[wr_addr] <= c;
        end
        rd_data_reg <= dstore[rd_addr];
    end

    // Scanner state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= M_IDLE;
            dlen_reg    <= '0;
            mpos_reg    <= '0;
            depth_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                mode_reg  <= mode_next;
                dlen_reg  <= dlen_next;
                mpos_reg  <= mpos_next;
                depth_reg <= depth_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= res;
        end
    end

endmodule

### test/heredoc_and_nested_comment_scanner_top_test.sv
// Self-checking testbench for heredoc_and_nested_comment_scanner_top.
// Character beats are predicted by an in-bench scanner model and checked at the m_ port.
// Depends on hdnc_pkg and the scanner RTL.
`timescale 1ns / 100ps

module heredoc_and_nested_comment_scanner_top_test;

    typedef enum logic [3:0] {
        SCAN_IDLE, SCAN_HASH, SCAN_LT, SCAN_NAME_FIRST, SCAN_NAME,
        SCAN_BODY, SCAN_SKIP_LINE, SCAN_COMMENT, SCAN_CMT_HASH, SCAN_CMT_BAR
    } scan_mode_t;

    localparam string BODY_CHARS    = "ab_Z9 )]#|\t\r";
    localparam string COMMENT_CHARS = "ab \n*(";
    localparam string WS_CHARS      = " \t\r\n";

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    hdnc_pkg::in_beat_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    hdnc_pkg::out_beat_t m_data;

    // Scanner state as predicted
    scan_mode_t sc_mode  = SCAN_IDLE;
    logic [7:0] sc_delim [0:hdnc_pkg::MAX_DELIMITER-1];
    int         sc_dlen  = 0;
    int         sc_pos   = 0;
    int         sc_depth = 0;

    hdnc_pkg::in_beat_t  char_beats[$];
    hdnc_pkg::out_beat_t expected_results[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int pushed_total  = 0;
    int checked_total = 0;
    int token_beats   = 0;
    int fail_count    = 0;
    int status_seen [0:7];

    heredoc_and_nested_comment_scanner_top i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #4 aclk = ~aclk;

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Advance the predicted scanner by one character beat
    function automatic hdnc_pkg::out_beat_t predict_scan(input hdnc_pkg::in_beat_t b);
        hdnc_pkg::out_beat_t r;
        logic [7:0] c;
        logic       eoi;
        c   = b.ch;
        eoi = b.at_end;
        r.status   = hdnc_pkg::ST_CONT;
        r.in_token = 1'b0;
        case (sc_mode)
            SCAN_HASH: begin
                if (!eoi && c == hdnc_pkg::CH_LT && b.heredoc_ok) begin
                    sc_mode = SCAN_LT;
                    r.in_token = 1'b1;
                end else if (!eoi && c == hdnc_pkg::CH_BAR && b.comment_ok) begin
                    sc_mode = SCAN_COMMENT;
                    sc_depth = 1;
                    r.in_token = 1'b1;
                end else begin
                    r.status = hdnc_pkg::ST_REJECT;
                end
            end
            SCAN_LT: begin
                if (!eoi && c == hdnc_pkg::CH_LT) begin
                    sc_mode = SCAN_NAME_FIRST;
                    r.in_token = 1'b1;
                end else begin
                    r.status = hdnc_pkg::ST_REJECT;
                end
            end
            SCAN_NAME_FIRST: begin
                if (!eoi && c inside {[8'h41:8'h5A], [8'h61:8'h7A], 8'h5F}) begin
                    sc_delim[0] = c;
                    sc_dlen = 1;
                    sc_mode = SCAN_NAME;
                    r.in_token = 1'b1;
                end else begin
                    r.status = hdnc_pkg::ST_REJECT;
                end
            end
            SCAN_NAME: begin
                if (eoi) begin
                    r.status = hdnc_pkg::ST_REJECT;
                end else if (c inside {[8'h41:8'h5A], [8'h61:8'h7A], 8'h5F, [8'h30:8'h39]}) begin
                    if (sc_dlen >= hdnc_pkg::MAX_DELIMITER - 1) begin
                        r.status = hdnc_pkg::ST_REJECT;
                    end else begin
                        sc_delim[sc_dlen] = c;
                        sc_dlen++;
                        r.in_token = 1'b1;
                    end
                end else if (c == hdnc_pkg::CH_LF) begin
                    sc_mode = SCAN_BODY;
                    sc_pos = 0;
                    r.in_token = 1'b1;
                end else begin
                    r.status = hdnc_pkg::ST_REJECT;
                end
            end
            SCAN_BODY: begin
                // Match the delimiter at line start; any miss skips to the next line
                if (eoi) begin
                    r.status = hdnc_pkg::ST_HD_EOF;
                end else if (sc_pos < sc_dlen && c == sc_delim[sc_pos]) begin
                    sc_pos++;
                    r.in_token = 1'b1;
                end else if (sc_pos < sc_dlen ||
                             !(c inside {hdnc_pkg::CH_LF, hdnc_pkg::CH_CR, hdnc_pkg::CH_SP,
                                         hdnc_pkg::CH_RPAR, hdnc_pkg::CH_RBRK})) begin
                    sc_mode = (c == hdnc_pkg::CH_LF) ? SCAN_BODY : SCAN_SKIP_LINE;
                    sc_pos = 0;
                    r.in_token = 1'b1;
                end else begin
                    r.status = hdnc_pkg::ST_HD_END;
                end
            end
            SCAN_SKIP_LINE: begin
                if (eoi) begin
                    r.status = hdnc_pkg::ST_HD_EOF;
                end else begin
                    r.in_token = 1'b1;
                    if (c == hdnc_pkg::CH_LF) begin
                        sc_mode = SCAN_BODY;
                        sc_pos = 0;
                    end
                end
            end
            SCAN_COMMENT, SCAN_CMT_HASH, SCAN_CMT_BAR: begin
                if (eoi) begin
                    r.status = hdnc_pkg::ST_CM_EOF;
                end else begin
                    r.in_token = 1'b1;
                    if (sc_mode == SCAN_CMT_HASH && c == hdnc_pkg::CH_BAR) begin
                        if (sc_depth < hdnc_pkg::MAX_NESTING) sc_depth++;
                        sc_mode = SCAN_COMMENT;
                    end else if (sc_mode == SCAN_CMT_BAR && c == hdnc_pkg::CH_HASH) begin
                        if (sc_depth > 0) sc_depth--;
                        if (sc_depth == 0) r.status = hdnc_pkg::ST_CM_END;
                        else sc_mode = SCAN_COMMENT;
                    end else if (c == hdnc_pkg::CH_HASH) begin
                        sc_mode = SCAN_CMT_HASH;
                    end else if (c == hdnc_pkg::CH_BAR) begin
                        sc_mode = SCAN_CMT_BAR;
                    end else begin
                        sc_mode = SCAN_COMMENT;
                    end
                end
            end
            default: begin
                if (eoi) begin
                    r.status = hdnc_pkg::ST_REJECT;
                end else if (c inside {hdnc_pkg::CH_SP, hdnc_pkg::CH_TAB,
                                       hdnc_pkg::CH_CR, hdnc_pkg::CH_LF}) begin
                    sc_mode = SCAN_IDLE;
                end else if (c == hdnc_pkg::CH_HASH) begin
                    sc_mode = SCAN_HASH;
                    r.in_token = 1'b1;
                end else begin
                    r.status = hdnc_pkg::ST_REJECT;
                end
            end
        endcase
        if (r.status != hdnc_pkg::ST_CONT) sc_mode = SCAN_IDLE;
        return r;
    endfunction

    // Driver: present the next pending character beat
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            sc_mode  = SCAN_IDLE;
            sc_dlen  = 0;
            sc_pos   = 0;
            sc_depth = 0;
        end else begin
            if (s_valid && s_ready) expected_results.push_back(predict_scan(s_data));
            if (!s_valid || s_ready) begin
                if (char_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= char_beats.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic note_failure(input string msg);
        if (fail_count < 10) $display("MISMATCH at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    // Monitor: compare each result beat with the oldest prediction
    always @(posedge aclk) begin
        hdnc_pkg::out_beat_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    note_failure($sformatf("result status=%0d in_token=%0b with none pending",
                                           m_data.status, m_data.in_token));
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.status !== want.status)
                        note_failure($sformatf("beat %0d status exp %0d got %0d",
                                               checked_total, want.status, m_data.status));
                    if (m_data.in_token !== want.in_token)
                        note_failure($sformatf("beat %0d in_token exp %0b got %0b",
                                               checked_total, want.in_token, m_data.in_token));
                end
                status_seen[m_data.status]++;
                if (m_data.in_token === 1'b1) token_beats++;
                checked_total++;
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Stimulus helpers
    task automatic push_beat(input logic [7:0] c, input logic e, input logic h, input logic k);
        hdnc_pkg::in_beat_t b;
        b.ch = c;
        b.at_end = e;
        b.heredoc_ok = h;
        b.comment_ok = k;
        char_beats.push_back(b);
        pushed_total++;
    endtask

    // Token permission flags are mostly granted
    function automatic logic ok_flag();
        return $urandom_range(19) != 0;
    endfunction

    task automatic push_char(input logic [7:0] c);
        push_beat(c, 1'b0, ok_flag(), ok_flag());
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_beat(s[i], 1'b0, 1'b1, 1'b1);
    endtask

    function automatic logic [7:0] name_char(input bit first);
        int k;
        k = $urandom_range(first ? 52 : 62);
        if (k < 26) return 8'(8'h41 + k);
        if (k < 52) return 8'(8'h61 + k - 26);
        if (k == 52) return 8'h5F;
        return 8'(8'h30 + k - 53);
    endfunction

    function automatic logic [7:0] body_char();
        if ($urandom_range(4) == 0) return 8'($urandom_range(255));
        return BODY_CHARS[$urandom_range(BODY_CHARS.len() - 1)];
    endfunction

    // "#<<NAME\n", a few body lines, then a closing line, end of input or nothing; or a broken prefix
    task automatic gen_heredoc(input int name_len, input bit clean);
        logic [7:0] nm[$];
        int         cut;
        push_char(hdnc_pkg::CH_HASH);
        push_beat(hdnc_pkg::CH_LT, 1'b0, clean | ok_flag(), ok_flag());
        push_char(hdnc_pkg::CH_LT);
        for (int i = 0; i < name_len; i++) begin
            nm.push_back(name_char(i == 0));
            push_char(nm[i]);
        end
        if (!clean && $urandom_range(9) == 0) begin
            // broken prefix
            push_beat(8'($urandom_range(255)), $urandom_range(3) == 0, ok_flag(), ok_flag());
            return;
        end
        push_char(hdnc_pkg::CH_LF);
        repeat (clean ? 1 : $urandom_range(3)) begin
            case ($urandom_range(3))
                0: repeat ($urandom_range(6)) push_char(body_char());
                1: begin
                    foreach (nm[i]) push_char(nm[i]);
                    push_char(name_char(1'b0));
                    repeat ($urandom_range(3)) push_char(body_char());
                end
                2: begin
                    cut = $urandom_range(nm.size() - 1);
                    for (int i = 0; i < cut; i++) push_char(nm[i]);
                    push_char(body_char());
                end
                default: ;
            endcase
            push_char(hdnc_pkg::CH_LF);
        end
        case (clean ? 9 : $urandom_range(9))
            0, 1: push_beat(8'($urandom_range(255)), 1'b1, ok_flag(), ok_flag());
            2: ;
            default: begin
                foreach (nm[i]) push_char(nm[i]);
                case ($urandom_range(4))
                    0: push_char(hdnc_pkg::CH_LF);
                    1: push_char(hdnc_pkg::CH_CR);
                    2: push_char(hdnc_pkg::CH_SP);
                    3: push_char(hdnc_pkg::CH_RPAR);
                    default: push_char(hdnc_pkg::CH_RBRK);
                endcase
            end
        endcase
    endtask

    // "#|" with random nesting and filler, closed or cut off by end of input
    task automatic gen_comment(input int len);
        int depth;
        depth = 1;
        push_char(hdnc_pkg::CH_HASH);
        push_char(hdnc_pkg::CH_BAR);
        repeat (len) begin
            case ($urandom_range(5))
                0: begin
                    push_char(hdnc_pkg::CH_HASH);
                    push_char(hdnc_pkg::CH_BAR);
                    depth++;
                end
                1: if (depth > 1) begin
                    push_char(hdnc_pkg::CH_BAR);
                    push_char(hdnc_pkg::CH_HASH);
                    depth--;
                end
                2: push_char(8'($urandom_range(255)));
                default: push_char(COMMENT_CHARS[$urandom_range(COMMENT_CHARS.len() - 1)]);
            endcase
        end
        if ($urandom_range(4) == 0) begin
            push_beat(8'($urandom_range(255)), 1'b1, ok_flag(), ok_flag());
        end else begin
            repeat (depth) begin
                push_char(hdnc_pkg::CH_BAR);
                push_char(hdnc_pkg::CH_HASH);
            end
        end
    endtask

    task automatic wait_drained();
        while (checked_total < pushed_total) @(posedge aclk);
    endtask

    // Stimulus: three pacing phases, draining fully between them
    initial begin
        int start;
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin send_idle_pct = 31; recv_idle_pct = 85; end
                1: begin send_idle_pct = 85; recv_idle_pct = 31; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            if (ph == 0) begin
                push_text(" \t\r\n");
                push_beat(8'hFF, 1'b0, 1'b1, 1'b1);                 // stray char from idle
                push_beat(hdnc_pkg::CH_SP, 1'b1, 1'b1, 1'b1);       // end of input while idle
                push_beat(hdnc_pkg::CH_HASH, 1'b0, 1'b1, 1'b1);
                push_beat(8'h00, 1'b1, 1'b1, 1'b1);                 // end right after '#'
                push_beat(hdnc_pkg::CH_HASH, 1'b0, 1'b1, 1'b1);
                push_beat(hdnc_pkg::CH_LT, 1'b0, 1'b0, 1'b1);       // heredoc not allowed
                push_beat(hdnc_pkg::CH_HASH, 1'b0, 1'b1, 1'b1);
                push_beat(hdnc_pkg::CH_BAR, 1'b0, 1'b1, 1'b0);      // comment not allowed
                push_text("#<<Q\nQ]");                              // heredoc closed by ']'
                push_text("#|#||#|#");                              // nested comment closes
                push_text("#|");
                push_beat(8'h00, 1'b1, 1'b1, 1'b1);                 // comment cut off
            end
            if (ph == 2) begin
                // longest delimiter fills, then one char too many is rejected
                push_text("#<<");
                repeat (hdnc_pkg::MAX_DELIMITER) push_beat(name_char(1'b1), 1'b0, 1'b1, 1'b1);
            end
            start = pushed_total;
            while (pushed_total - start < 270) begin
                case ($urandom_range(9))
                    0, 1, 2, 3: gen_heredoc($urandom_range(7) == 0 ? $urandom_range(7, 20)
                                                                  : $urandom_range(1, 6), 1'b0);
                    4, 5, 6: gen_comment($urandom_range(12));
                    7: repeat ($urandom_range(1, 3)) push_char(WS_CHARS[$urandom_range(3)]);
                    default: repeat ($urandom_range(1, 3))
                        push_beat(8'($urandom_range(255)), $urandom_range(7) == 0,
                                  1'($urandom_range(1)), 1'($urandom_range(1)));
                endcase
            end
            wait_drained();
        end
        repeat (8) @(posedge aclk);
        if (expected_results.size() != 0)
            note_failure($sformatf("%0d results never arrived", expected_results.size()));
        $display("Scanned %0d character beats (%0d inside tokens) over three pacing phases.",
                 checked_total, token_beats);
        $display("Heredocs closed %0d / at end %0d, comments closed %0d / at end %0d, rejects %0d.",
                 status_seen[hdnc_pkg::ST_HD_END], status_seen[hdnc_pkg::ST_HD_EOF],
                 status_seen[hdnc_pkg::ST_CM_END], status_seen[hdnc_pkg::ST_CM_EOF],
                 status_seen[hdnc_pkg::ST_REJECT]);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("Timeout with %0d of %0d beats checked", checked_total, pushed_total);
        $display("== FAIL ==");
        $finish;
    end

endmodule
